### rtl/bbs_pkg.sv
// ----------------------------------------------------------------------------
// bbs_pkg: shared types and constants for the BBS bit generator
// Widths, register indexes, reset values, sequencer states and the
// control/status bundles between the top level and the squaring core.
// ----------------------------------------------------------------------------
package bbs_pkg;

  localparam int MOD_BITS      = 64;
  localparam int CNT_BITS      = 12;
  localparam int IDX_BITS      = $clog2(MOD_BITS);
  localparam int CFG_ADDR_BITS = 2;
  localparam int IN_TDATA_BITS  = 8;
  localparam int OUT_TDATA_BITS = 8;

  localparam logic [MOD_BITS-1:0] MODULUS_RESET = MOD_BITS'(209);
  localparam logic [MOD_BITS-1:0] SEED_RESET    = MOD_BITS'(3);
  localparam logic [CNT_BITS-1:0] RUN_RESET     = CNT_BITS'(63);

  // configuration register indexes
  localparam logic [CFG_ADDR_BITS-1:0] CFG_MODULUS    = CFG_ADDR_BITS'(0);
  localparam logic [CFG_ADDR_BITS-1:0] CFG_SEED       = CFG_ADDR_BITS'(1);
  localparam logic [CFG_ADDR_BITS-1:0] CFG_RUN_LENGTH = CFG_ADDR_BITS'(2);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DBL,
    ST_ADD,
    ST_DONE
  } sq_state_t;

  typedef struct packed {
    logic start;
    logic ack;
  } core_ctrl_t;

  typedef struct packed {
    logic idle;
    logic done;
  } core_stat_t;

endpackage

### rtl/bbs_modadd.sv
// ----------------------------------------------------------------------------
// bbs_modadd: shared modular adder
// Returns (a + b) mod m for a, b below m, or the plain truncated sum when
// wrap is set (modulus taken as 2^MOD_BITS).
// ----------------------------------------------------------------------------
module bbs_modadd (
  input  logic [bbs_pkg::MOD_BITS-1:0] a,
  input  logic [bbs_pkg::MOD_BITS-1:0] b,
  input  logic [bbs_pkg::MOD_BITS-1:0] m,
  input  logic                         wrap,
  output logic [bbs_pkg::MOD_BITS-1:0] y
);

  logic [bbs_pkg::MOD_BITS:0]   sum;
  logic [bbs_pkg::MOD_BITS+1:0] diff;

  assign sum  = {1'b0, a} + {1'b0, b};
  assign diff = {1'b0, sum} - {2'b00, m};

  always_comb begin
    if (wrap || diff[bbs_pkg::MOD_BITS+1]) begin
      y = sum[bbs_pkg::MOD_BITS-1:0];
    end else begin
      y = diff[bbs_pkg::MOD_BITS-1:0];
    end
  end

endmodule

### rtl/bbs_core.sv
// ----------------------------------------------------------------------------
// bbs_core: iterative modular squarer
// Double-and-add over the operand bits, MSB first, one modular add per
// cycle. An operand at or above the modulus is first reduced by the same
// loop with addend one.
// ----------------------------------------------------------------------------
module bbs_core (
  input  logic                         clk,
  input  logic                         rst,
  input  bbs_pkg::core_ctrl_t          ctrl,
  input  logic [bbs_pkg::MOD_BITS-1:0] operand,
  input  logic [bbs_pkg::MOD_BITS-1:0] modulus,
  output bbs_pkg::core_stat_t          stat,
  output logic [bbs_pkg::MOD_BITS-1:0] result
);

  bbs_pkg::sq_state_t state, state_next;

  logic [bbs_pkg::MOD_BITS-1:0] r;
  logic [bbs_pkg::MOD_BITS-1:0] src;
  logic [bbs_pkg::MOD_BITS-1:0] mod_q;
  logic                         wrap;
  logic                         red;    // reduction pass running
  logic [bbs_pkg::IDX_BITS-1:0] idx;

  logic [bbs_pkg::MOD_BITS-1:0] addend;
  logic [bbs_pkg::MOD_BITS-1:0] unit_b;
  logic [bbs_pkg::MOD_BITS-1:0] unit_y;
  logic                         step_done;  // this cycle finishes bit idx
  logic                         pass_end;
  logic                         mod_one;

  assign mod_one   = (modulus == bbs_pkg::MOD_BITS'(1));
  assign addend    = red ? bbs_pkg::MOD_BITS'(1) : src;
  assign unit_b    = (state == bbs_pkg::ST_ADD) ? addend : r;
  assign step_done = (state == bbs_pkg::ST_ADD) || !src[idx];
  assign pass_end  = step_done && (idx == '0);

  bbs_modadd u_modadd (
    .a    (r),
    .b    (unit_b),
    .m    (mod_q),
    .wrap (wrap),
    .y    (unit_y)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      bbs_pkg::ST_IDLE: begin
        if (ctrl.start) begin
          state_next = mod_one ? bbs_pkg::ST_DONE : bbs_pkg::ST_DBL;
        end
      end
      bbs_pkg::ST_DBL: begin
        if (src[idx]) begin
          state_next = bbs_pkg::ST_ADD;
        end else if (pass_end && !red) begin
          state_next = bbs_pkg::ST_DONE;
        end else begin
          state_next = bbs_pkg::ST_DBL;
        end
      end
      bbs_pkg::ST_ADD: begin
        state_next = (pass_end && !red) ? bbs_pkg::ST_DONE : bbs_pkg::ST_DBL;
      end
      bbs_pkg::ST_DONE: begin
        if (ctrl.ack) begin
          state_next = bbs_pkg::ST_IDLE;
        end
      end
      default: state_next = bbs_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    stat.idle = (state == bbs_pkg::ST_IDLE);
    stat.done = (state == bbs_pkg::ST_DONE);
    result    = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bbs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      red <= 1'b0;
    end else begin
      priority case (1'b1)
        (state == bbs_pkg::ST_IDLE) && ctrl.start: begin
          red <= (modulus > bbs_pkg::MOD_BITS'(1)) && (operand >= modulus);
        end
        (state == bbs_pkg::ST_DBL) || (state == bbs_pkg::ST_ADD): begin
          if (pass_end) begin
            red <= 1'b0;
          end
        end
        default: red <= red;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state == bbs_pkg::ST_IDLE && ctrl.start) begin
      mod_q <= modulus;
      wrap  <= (modulus == '0);
      src   <= operand;
      r     <= '0;
      idx   <= '1;
    end else if (state == bbs_pkg::ST_DBL || state == bbs_pkg::ST_ADD) begin
      if (pass_end && red) begin
        // reduced operand becomes the multiplier for the squaring pass
        src <= unit_y;
        r   <= '0;
        idx <= '1;
      end else begin
        r <= unit_y;
        if (step_done) begin
          idx <= idx - bbs_pkg::IDX_BITS'(1);
        end
      end
    end
  end

endmodule

### rtl/bbs_bit_generator_unit.sv
// ----------------------------------------------------------------------------
// bbs_bit_generator_unit: Blum Blum Shub bit generator
// Each request squares the kept state modulo the configured modulus and
// returns the parity of the new state, with run end and zero-state flags.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_*: one request per item, s_tdata[0] = restart (reload the
//   state from the seed and clear the bit count before stepping).
//   Master channel m_*: one result per request; m_tdata[0] = random_bit,
//   m_tlast = run end (count reached run_length or zero state),
//   m_tuser = state_zero.
//   Config: cfg_we writes cfg_wdata to register cfg_addr (0 modulus, 1 seed,
//   2 run_length); write only while no request is in flight.
// Sequence: an accept state, then a doubling step per operand bit plus an add
//   step per set bit, then a result state. A state at or above the modulus
//   first takes a reduction pass of the same shape. Modulus one goes from the
//   accept state straight to the result state. All steps share one 64-bit
//   modular adder, so one request is in work at a time.
// Reset: state = 3, bit count = 0, modulus 209, seed 3, run_length 63.
// Stall: a finished result waits in the output register; the next request is
//   accepted meanwhile and its result is held in the core until m_tready.
// ----------------------------------------------------------------------------
module bbs_bit_generator_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [bbs_pkg::IN_TDATA_BITS-1:0]  s_tdata,   // [0] restart
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [bbs_pkg::OUT_TDATA_BITS-1:0] m_tdata,   // [0] random_bit
  output logic                               m_tlast,
  output logic                               m_tuser,   // [0] state_zero
  input  logic                               cfg_we,
  input  logic [bbs_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
  input  logic [bbs_pkg::MOD_BITS-1:0]       cfg_wdata
);

  logic [bbs_pkg::MOD_BITS-1:0] modulus;
  logic [bbs_pkg::MOD_BITS-1:0] seed;
  logic [bbs_pkg::CNT_BITS-1:0] run_length;
  logic [bbs_pkg::MOD_BITS-1:0] sq_state;
  logic [bbs_pkg::CNT_BITS-1:0] bit_index;

  bbs_pkg::core_ctrl_t          ctrl;
  bbs_pkg::core_stat_t          stat;
  logic [bbs_pkg::MOD_BITS-1:0] operand;
  logic [bbs_pkg::MOD_BITS-1:0] result;

  logic                         accept;
  logic                         restart;
  logic                         load_out;
  logic                         zero;
  logic                         last;
  logic [bbs_pkg::CNT_BITS-1:0] count;
  logic                         out_bit;

  assign restart  = s_tdata[0];
  assign s_tready = stat.idle;
  assign accept   = s_tvalid && s_tready;
  assign load_out = stat.done && (!m_tvalid || m_tready);
  assign operand  = restart ? seed : sq_state;

  assign ctrl.start = accept;
  assign ctrl.ack   = load_out;

  assign zero  = (result == '0);
  assign count = bit_index + bbs_pkg::CNT_BITS'(1);
  assign last  = zero || (count >= run_length) || (count == '0);

  bbs_core u_core (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .operand (operand),
    .modulus (modulus),
    .stat    (stat),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus    <= bbs_pkg::MODULUS_RESET;
      seed       <= bbs_pkg::SEED_RESET;
      run_length <= bbs_pkg::RUN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        bbs_pkg::CFG_MODULUS:    modulus    <= cfg_wdata;
        bbs_pkg::CFG_SEED:       seed       <= cfg_wdata;
        bbs_pkg::CFG_RUN_LENGTH: run_length <= cfg_wdata[bbs_pkg::CNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_state  <= bbs_pkg::SEED_RESET;
      bit_index <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (accept && restart) begin
        sq_state  <= seed;
        bit_index <= '0;
      end
      if (load_out) begin
        sq_state  <= result;
        bit_index <= last ? '0 : count;
        m_tvalid  <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_bit <= result[0];
      m_tlast <= last;
      m_tuser <= zero;
    end
  end

  assign m_tdata = {{(bbs_pkg::OUT_TDATA_BITS-1){1'b0}}, out_bit};

  // one request in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("request accepted while core busy");

  // zero state always ends the run
  a_zero_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("zero state without run end");

  // zero state has even parity
  a_zero_bit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> !m_tdata[0])
    else $error("zero state with odd bit");

  // a result is only taken from the core when the output slot is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
    else $error("pending result overwritten");

endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for bbs_bit_generator_unit
// Drives restart/step requests on the slave stream and checks each result
// (random bit, run end, zero state) against a local squaring predictor.
// A short directed table covers the modulus and run-length corners, then
// random phases change the configuration between drained stretches.
// ----------------------------------------------------------------------------
module tb_top;
  import bbs_pkg::*;

  localparam logic [CFG_ADDR_BITS-1:0] CFG_SPARE = CFG_ADDR_BITS'(3);
  localparam logic [MOD_BITS-1:0] ALL_ONES = {MOD_BITS{1'b1}};
  localparam logic [MOD_BITS-1:0] BIG_BLUM = 64'd4294967291 * 64'd4294967279;
  localparam longint CYCLE_LIMIT  = 4000000;
  localparam int     DRAIN_CYCLES = 300;
  localparam int     PHASES       = 8;
  localparam int     PHASE_ITEMS  = 216;

  typedef struct packed {
    logic random_bit;
    logic last;
    logic state_zero;
  } bbs_result_t;

  typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;
  typedef enum logic [1:0] { RX_OPEN, RX_THROTTLE, RX_RANDOM, RX_BURSTY } rx_mode_t;

  typedef struct {
    row_kind_t                kind;
    logic [CFG_ADDR_BITS-1:0] addr;
    logic [MOD_BITS-1:0]      value;
    bit                       restart;
    bit                       typed;
    bbs_result_t              want;
  } dir_row_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [IN_TDATA_BITS-1:0]  s_tdata = '0;    // [0] restart
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0] m_tdata;         // [0] random_bit
  logic                      m_tlast;
  logic                      m_tuser;         // [0] state_zero
  logic                      cfg_we = 1'b0;
  logic [CFG_ADDR_BITS-1:0]  cfg_addr = '0;
  logic [MOD_BITS-1:0]       cfg_wdata = '0;

  bbs_bit_generator_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // predictor copy of registers and state
  logic [MOD_BITS-1:0] mod_q, seed_q, sq_state;
  logic [CNT_BITS-1:0] run_len_q, bit_cnt;

  bbs_result_t pending_bits[$];
  dir_row_t    dir_rows[$];
  bbs_result_t mon_want;

  longint   cycle_cnt = 0;
  int       err_cnt = 0, req_cnt = 0, restart_cnt = 0, checked_cnt = 0;
  int       run_end_cnt = 0, zero_cnt = 0, cfg_writes = 0, burst_left = 0;
  int       restart_pct;
  rx_mode_t rx_mode = RX_OPEN;
  logic [7:0] rx_cnt = '0;

  function automatic bbs_result_t bbs_next_bit(bit restart);
    logic [2*MOD_BITS-1:0] sq;
    logic [MOD_BITS-1:0]   nxt;
    logic [CNT_BITS-1:0]   cnt;
    bbs_result_t           r;
    if (restart) begin
      sq_state = seed_q;
      bit_cnt  = '0;
    end
    sq = {{MOD_BITS{1'b0}}, sq_state} * {{MOD_BITS{1'b0}}, sq_state};
    // modulus zero means 2**64: keep the low half
    if (mod_q == '0) nxt = sq[MOD_BITS-1:0];
    else nxt = MOD_BITS'(sq % {{MOD_BITS{1'b0}}, mod_q});
    sq_state     = nxt;
    cnt          = bit_cnt + CNT_BITS'(1);
    r.random_bit = nxt[0];
    r.state_zero = (nxt == '0);
    r.last       = r.state_zero || (cnt >= run_len_q) || (cnt == '0);
    bit_cnt      = r.last ? '0 : cnt;
    return r;
  endfunction

  function automatic void add_item(bit restart, bit typed, logic [2:0] want);
    dir_rows.push_back('{ROW_ITEM, '0, '0, restart, typed, want});
  endfunction

  function automatic void add_cfg(logic [CFG_ADDR_BITS-1:0] addr, logic [MOD_BITS-1:0] value);
    dir_rows.push_back('{ROW_CFG, addr, value, 1'b0, 1'b0, 3'b000});
  endfunction

  // one register write, then an idle wait with cfg_we low so back-to-back writes never collide
  task automatic write_reg(logic [CFG_ADDR_BITS-1:0] addr, logic [MOD_BITS-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (addr)
      CFG_MODULUS:    mod_q = value;
      CFG_SEED:       seed_q = value;
      CFG_RUN_LENGTH: run_len_q = value[CNT_BITS-1:0];
      default: ;
    endcase
    cfg_writes++;
    @(posedge clk);
  endtask

  task automatic wait_idle;
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_bits.size() != 0);
  endtask

  // holds the request until accepted; valid is left high for the caller
  task automatic send_req(bit restart, bit typed, bbs_result_t want);
    bbs_result_t r;
    s_tvalid <= 1'b1;
    s_tdata  <= IN_TDATA_BITS'(restart);
    do @(posedge clk); while (!s_tready);
    r = bbs_next_bit(restart);
    pending_bits.push_back(typed ? want : r);
    req_cnt++;
    if (restart) restart_cnt++;
  endtask

  task automatic idle_gap;
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  endtask

  // receiver stall pattern; a new mode is drawn each time the 8-bit rx_cnt wraps
  always @(posedge clk) begin
    rx_cnt <= rx_cnt + 8'd1;
    if (rx_cnt == 8'hFF) rx_mode <= rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:     m_tready <= 1'b1;
      RX_THROTTLE: m_tready <= (rx_cnt[1:0] != 2'b00);
      RX_RANDOM:   m_tready <= 1'($urandom_range(0, 1));
      default:     m_tready <= (rx_cnt[4:0] < 5'd4);
    endcase
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_bits.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual bit %0b last %0b zero %0b",
                 $time, m_tdata[0], m_tlast, m_tuser);
        err_cnt++;
      end else begin
        mon_want = pending_bits.pop_front();
        if (m_tdata[0] !== mon_want.random_bit) begin
          $display("%0t: random_bit expected %0b actual %0b", $time, mon_want.random_bit,
                   m_tdata[0]);
          err_cnt++;
        end
        if (m_tlast !== mon_want.last) begin
          $display("%0t: last expected %0b actual %0b", $time, mon_want.last, m_tlast);
          err_cnt++;
        end
        if (m_tuser !== mon_want.state_zero) begin
          $display("%0t: state_zero expected %0b actual %0b", $time, mon_want.state_zero,
                   m_tuser);
          err_cnt++;
        end
        checked_cnt++;
        if (mon_want.last) run_end_cnt++;
        if (mon_want.state_zero) zero_cnt++;
      end
    end
  end

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    mod_q     = MODULUS_RESET;
    seed_q    = SEED_RESET;
    run_len_q = RUN_RESET;
    sq_state  = SEED_RESET;
    bit_cnt   = '0;

    // reset values: 3 -> 9 -> 81 -> 82 mod 209
    add_item(1'b0, 1'b1, 3'b100);
    add_item(1'b0, 1'b1, 3'b100);
    add_item(1'b0, 1'b1, 3'b000);
    add_item(1'b1, 1'b1, 3'b100);
    add_cfg(CFG_RUN_LENGTH, 64'd1);
    add_item(1'b0, 1'b1, 3'b110);
    // modulus one: always zero, degenerate
    add_cfg(CFG_MODULUS, 64'd1);
    add_item(1'b0, 1'b1, 3'b011);
    add_item(1'b1, 1'b1, 3'b011);
    // modulus zero wraps at 2**64; run length zero ends every run
    add_cfg(CFG_MODULUS, 64'd0);
    add_cfg(CFG_SEED, ALL_ONES);
    add_cfg(CFG_RUN_LENGTH, 64'd0);
    add_item(1'b1, 1'b1, 3'b110);
    add_item(1'b0, 1'b1, 3'b110);
    // (n-1)^2 = 1 mod n at the widest modulus
    add_cfg(CFG_MODULUS, ALL_ONES);
    add_cfg(CFG_SEED, ALL_ONES - 64'd1);
    add_cfg(CFG_RUN_LENGTH, 64'd4095);
    add_item(1'b1, 1'b1, 3'b100);
    add_item(1'b0, 1'b1, 3'b100);
    // run length lowered below the current count
    add_cfg(CFG_RUN_LENGTH, 64'd1);
    add_item(1'b0, 1'b1, 3'b110);
    // seed equal to modulus reduces to zero
    add_cfg(CFG_SEED, ALL_ONES);
    add_item(1'b1, 1'b1, 3'b011);
    add_item(1'b0, 1'b1, 3'b011);
    add_cfg(CFG_MODULUS, 64'd3);
    add_cfg(CFG_SEED, 64'd0);
    add_item(1'b1, 1'b1, 3'b011);
    add_cfg(CFG_SEED, 64'd2);
    add_cfg(CFG_RUN_LENGTH, 64'd2);
    add_item(1'b1, 1'b1, 3'b100);
    add_item(1'b0, 1'b1, 3'b110);
    add_item(1'b0, 1'b1, 3'b100);
    // seed above modulus
    add_cfg(CFG_SEED, 64'd5);
    add_item(1'b1, 1'b1, 3'b100);
    add_cfg(CFG_MODULUS, 64'd2);
    add_cfg(CFG_SEED, 64'd3);
    add_item(1'b1, 1'b1, 3'b100);
    add_cfg(CFG_MODULUS, 64'd77);
    add_cfg(CFG_SEED, 64'd1000);
    add_cfg(CFG_RUN_LENGTH, 64'd4095);
    add_cfg(CFG_SPARE, ALL_ONES);
    add_item(1'b1, 1'b0, 3'b000);
    add_item(1'b0, 1'b0, 3'b000);
    add_item(1'b0, 1'b0, 3'b000);
    add_item(1'b0, 1'b0, 3'b000);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(dir_rows[i].addr, dir_rows[i].value);
      end else begin
        send_req(dir_rows[i].restart, dir_rows[i].typed, dir_rows[i].want);
        idle_gap();
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      case (p)
        0: begin
          write_reg(CFG_MODULUS, 64'd209);
          write_reg(CFG_SEED, MOD_BITS'($urandom_range(2, 207)));
          write_reg(CFG_RUN_LENGTH, MOD_BITS'($urandom_range(1, 16)));
        end
        1: begin
          write_reg(CFG_MODULUS, 64'd77);
          write_reg(CFG_SEED, MOD_BITS'($urandom_range(2, 75)));
          write_reg(CFG_RUN_LENGTH, 64'd4095);
        end
        2: begin
          write_reg(CFG_MODULUS, BIG_BLUM);
          write_reg(CFG_SEED, {$urandom, $urandom});
          write_reg(CFG_RUN_LENGTH, MOD_BITS'($urandom_range(1, 64)));
        end
        // shorten the run while one is in progress
        3: write_reg(CFG_RUN_LENGTH, MOD_BITS'($urandom_range(1, 8)));
        4: begin
          write_reg(CFG_MODULUS, {$urandom, $urandom} | 64'd1);
          write_reg(CFG_SEED, {$urandom, $urandom});
          write_reg(CFG_RUN_LENGTH, 64'd0);
        end
        5: begin
          write_reg(CFG_MODULUS, MOD_BITS'($urandom_range(3, 5000)));
          write_reg(CFG_SEED, MOD_BITS'($urandom_range(1, 10000)));
          write_reg(CFG_RUN_LENGTH, MOD_BITS'($urandom_range(1, 32)));
        end
        6: begin
          write_reg(CFG_MODULUS, 64'd0);
          write_reg(CFG_SEED, {$urandom, $urandom});
          write_reg(CFG_RUN_LENGTH, MOD_BITS'($urandom_range(1, 100)));
        end
        default: begin
          write_reg(CFG_MODULUS, ALL_ONES);
          write_reg(CFG_SEED, {$urandom, $urandom});
          write_reg(CFG_RUN_LENGTH, 64'd4095);
          write_reg(CFG_SPARE, {$urandom, $urandom});
        end
      endcase
      restart_pct = (p == 3) ? 1 : $urandom_range(1, 12);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // hold off once mid-phase until the output side has caught up
        if (p == 2 && n == PHASE_ITEMS / 2) wait_idle();
        send_req($urandom_range(0, 99) < restart_pct, 1'b0, 3'b000);
        idle_gap();
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests (%0d restarts) and %0d checked results over %0d phases",
             req_cnt, restart_cnt, checked_cnt, PHASES);
    $display("saw %0d run ends, %0d zero-state results, %0d register writes",
             run_end_cnt, zero_cnt, cfg_writes);
    if (err_cnt == 0 && pending_bits.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

### files.f
rtl/bbs_pkg.sv
rtl/bbs_modadd.sv
rtl/bbs_core.sv
rtl/bbs_bit_generator_unit.sv
test/tb_top.sv
